/* rtl/core/crc_pkg.sv */
package crc_pkg;

    localparam int RadiusBits = 10;
    localparam int CoordBits  = 12;
    localparam int OffBits    = RadiusBits + 1;
    localparam int DecBits    = RadiusBits + 4;
    localparam int PointBits  = CoordBits + 1;
    localparam int PointCount = 8;
    localparam int IdxBits    = $clog2(PointCount);
    localparam int QueueDepth = 2;

    localparam logic OpStart = 1'b0;
    localparam logic OpStep  = 1'b1;

    localparam logic signed [DecBits-1:0] DecInit  = DecBits'(3);
    localparam logic signed [DecBits-1:0] DecInc   = DecBits'(6);
    localparam logic signed [DecBits-1:0] DecDiag  = DecBits'(10);

    // one queued step: either a done marker or the eight-point job
    typedef struct packed {
        logic                        done;
        logic signed [CoordBits-1:0] cx;
        logic signed [CoordBits-1:0] cy;
        logic        [OffBits-1:0]   a;
        logic        [OffBits-1:0]   b;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/core/crc_front.sv */
module crc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                opcode,
    input  logic signed [crc_pkg::CoordBits-1:0] center_x,
    input  logic signed [crc_pkg::CoordBits-1:0] center_y,
    input  logic        [crc_pkg::RadiusBits-1:0] radius,
    input  crc_pkg::queue_status_t              q_status,
    output logic                                push,
    output crc_pkg::cmd_t                       push_cmd
);
    import crc_pkg::*;

    logic        [OffBits-1:0]   cur_x_reg, cur_x_next;
    logic        [OffBits-1:0]   cur_y_reg, cur_y_next;
    logic signed [DecBits-1:0]   dec_reg, dec_next;
    logic                        active_reg, active_next;
    logic signed [CoordBits-1:0] cx_reg, cx_next;
    logic signed [CoordBits-1:0] cy_reg, cy_next;

    logic accept;
    logic signed [DecBits-1:0] x_ext, y_ext;

    assign req_ready = !q_status.full;
    assign accept    = req_valid && req_ready;
    assign push      = accept && (opcode == OpStep);
    assign x_ext     = DecBits'(cur_x_reg);
    assign y_ext     = DecBits'(cur_y_reg);

    always_comb
    begin
        push_cmd.done = !active_reg;
        push_cmd.cx   = cx_reg;
        push_cmd.cy   = cy_reg;
        push_cmd.a    = cur_x_reg;
        push_cmd.b    = cur_y_reg;
    end

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        dec_next    = dec_reg;
        active_next = active_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        if (accept)
        begin
            if (opcode == OpStart)
            begin
                cx_next     = center_x;
                cy_next     = center_y;
                cur_x_next  = '0;
                cur_y_next  = OffBits'(radius);
                dec_next    = DecInit - (DecBits'(radius) <<< 1);
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                if (cur_x_reg < cur_y_reg)
                begin
                    if (dec_reg[DecBits-1])
                    begin
                        dec_next = dec_reg + (x_ext <<< 2) + DecInc;
                    end
                    else
                    begin
                        dec_next   = dec_reg + ((x_ext - y_ext) <<< 2) + DecDiag;
                        cur_y_next = cur_y_reg - OffBits'(1);
                    end
                    cur_x_next = cur_x_reg + OffBits'(1);
                    if (cur_x_next > cur_y_next)
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            dec_reg    <= dec_next;
            active_reg <= active_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
        end
    end

endmodule

/* rtl/core/crc_queue.sv */
module crc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  crc_pkg::cmd_t           push_cmd,
    input  logic                    pop,
    output crc_pkg::cmd_t           head_cmd,
    output crc_pkg::queue_status_t  status
);
    import crc_pkg::*;

    localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntBits = $clog2(QueueDepth + 1);

    cmd_t               mem_reg [QueueDepth];
    logic [PtrBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntBits-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == CntBits'(QueueDepth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(QueueDepth - 1)) ? '0
                                                                     : wr_ptr_reg + PtrBits'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(QueueDepth - 1)) ? '0
                                                                     : rd_ptr_reg + PtrBits'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntBits'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntBits'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/crc_back.sv */
module crc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  crc_pkg::queue_status_t               q_status,
    input  crc_pkg::cmd_t                        head_cmd,
    output logic                                 pop,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [crc_pkg::PointBits-1:0] point_x,
    output logic signed [crc_pkg::PointBits-1:0] point_y,
    output logic                                 last_of_step,
    output logic                                 done_res
);
    import crc_pkg::*;

    cmd_t               cmd_reg;
    logic               cmd_valid_reg;
    logic [IdxBits-1:0] idx_reg;

    logic                        out_valid_reg;
    logic signed [PointBits-1:0] px_reg, py_reg;
    logic                        last_reg, done_reg;

    logic advance, is_last;
    logic [OffBits-1:0] u, v;
    int   cx_i, cy_i, u_i, v_i, px_i, py_i;

    assign advance = cmd_valid_reg && (!out_valid_reg || res_ready);
    assign is_last = cmd_reg.done || (idx_reg == IdxBits'(PointCount - 1));
    assign pop     = !q_status.empty && (!cmd_valid_reg || (advance && is_last));

    // idx bit 2 swaps the octant pair, bit 1 mirrors y, bit 0 mirrors x
    always_comb
    begin
        u    = idx_reg[2] ? cmd_reg.b : cmd_reg.a;
        v    = idx_reg[2] ? cmd_reg.a : cmd_reg.b;
        cx_i = int'(cmd_reg.cx);
        cy_i = int'(cmd_reg.cy);
        u_i  = int'(u);
        v_i  = int'(v);
        px_i = idx_reg[0] ? (cx_i - u_i) : (cx_i + u_i);
        py_i = idx_reg[1] ? (cy_i - v_i) : (cy_i + v_i);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (advance)
        begin
            if (cmd_reg.done)
            begin
                px_reg <= '0;
                py_reg <= '0;
            end
            else
            begin
                px_reg <= px_i[PointBits-1:0];
                py_reg <= py_i[PointBits-1:0];
            end
            last_reg <= is_last;
            done_reg <= cmd_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cmd_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance)
            begin
                if (is_last)
                begin
                    cmd_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + IdxBits'(1);
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid    = out_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign last_of_step = last_reg;
    assign done_res     = done_reg;

endmodule

/* rtl/core/circle_rasterizer_core.sv */
// Midpoint circle rasterizer with eight-way symmetry. A start transaction
// (opcode 0) loads centre and radius and returns nothing; each
// step transaction (opcode 1) returns the eight mirrored points of the current
// octant offset, the eighth flagged last_of_step, or a single done_res result
// when no circle is active. The front end walks the decision variable and
// accepts one transaction per cycle while its two-entry command queue has
// room; the back end drains the queue and drives one point per cycle, while
// res_ready allows, through a registered output. Each step therefore holds
// the single point port of the back end for its eight points, and a done step
// for one result. Results keep input order; duplicate points on the axes are
// emitted as they fall. Coordinates wrap to 13 bits.
module circle_rasterizer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic                                  opcode,
    input  logic signed [crc_pkg::CoordBits-1:0]  center_x,
    input  logic signed [crc_pkg::CoordBits-1:0]  center_y,
    input  logic        [crc_pkg::RadiusBits-1:0] radius,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [crc_pkg::PointBits-1:0]  point_x,
    output logic signed [crc_pkg::PointBits-1:0]  point_y,
    output logic                                  last_of_step,
    output logic                                  done_res
);
    import crc_pkg::*;

    queue_status_t q_status;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    logic          push;
    logic          pop;

    // front: accept, classify, advance the octant walk
    crc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .opcode    (opcode),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decouples the walk from the point output
    crc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // back: mirror into eight points, one per cycle while res_ready allows
    crc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

endmodule
